// ===== hw/rtl/euclidean_distance_unit_defines.svh =====
// Assertion macros shared by the euclidean distance unit RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef EUCLIDEAN_DISTANCE_UNIT_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EDU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/edu_pkg.sv =====
// Package of the euclidean distance unit: widths, constants and shared types.
// Depends on nothing; used by every RTL module and interface of the block.
package edu_pkg;

    localparam int ELEM_W  = 16;
    localparam int DIFF_W  = ELEM_W + 1;
    localparam int SQ_W    = 2 * ELEM_W;
    localparam int ACC_W   = 43;
    localparam int SUM_W   = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
    localparam int DIST_W  = 22;
    localparam int RAD_W   = 2 * DIST_W;
    localparam int REM_W   = DIST_W + 2;
    localparam int CNT_W   = $clog2(DIST_W);
    localparam int Q_AW    = 1;
    localparam int Q_DEPTH = 1 << Q_AW;

    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // A finished sum of squares moving between the front, the queue and the back.
    typedef struct packed {
        logic             valid;
        logic [ACC_W-1:0] sum;
    } t_sum_xfer;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_DONE
    } t_back_state;

endpackage

// ===== hw/rtl/edu_if.sv =====
// Channel interfaces of the euclidean distance unit: element pairs in, results out.
// Depends on edu_pkg.
interface edu_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [edu_pkg::ELEM_W-1:0] elem_a;
    logic signed [edu_pkg::ELEM_W-1:0] elem_b;
    logic                             last;

    modport source (output valid, elem_a, elem_b, last, input ready);
    modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

interface edu_out_if;
    logic                        valid;
    logic                        ready;
    logic [edu_pkg::DIST_W-1:0]  distance;
    logic [edu_pkg::ACC_W-1:0]   squared_sum;

    modport source (output valid, distance, squared_sum, input ready);
    modport sink (input valid, distance, squared_sum, output ready);
endinterface

// ===== hw/rtl/edu_front.sv =====
// Front end: takes element pairs, squares their difference and accumulates
// with saturation; hands each finished vector sum to the queue.
// Depends on edu_pkg and edu_in_if.
module edu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    edu_in_if.sink              i_pair,
    input  logic                i_q_full,
    output edu_pkg::t_sum_xfer  o_push
);

    logic                          w_stall;
    logic                          w_adv;
    logic [edu_pkg::DIFF_W-1:0]    w_diff;
    logic [edu_pkg::DIFF_W-1:0]    w_abs;
    logic [edu_pkg::SUM_W-1:0]     w_sum;
    logic [edu_pkg::ACC_W-1:0]     w_sat;

    logic                          r_v1;
    logic                          r_last1;
    logic [edu_pkg::ELEM_W-1:0]    r_mag;
    logic                          r_v2;
    logic                          r_last2;
    logic [edu_pkg::SQ_W-1:0]      r_sq;
    logic [edu_pkg::ACC_W-1:0]     r_acc;

    // The pipe holds only when a vector end cannot enter a full queue.
    assign w_stall      = r_v2 && r_last2 && i_q_full;
    assign w_adv        = !w_stall;
    assign i_pair.ready = w_adv;

    always_comb begin
        w_diff = {i_pair.elem_a[edu_pkg::ELEM_W-1], i_pair.elem_a}
               - {i_pair.elem_b[edu_pkg::ELEM_W-1], i_pair.elem_b};
        w_abs  = w_diff[edu_pkg::DIFF_W-1] ? (~w_diff + 1'b1) : w_diff;
        w_sum  = edu_pkg::SUM_W'(r_acc) + edu_pkg::SUM_W'(r_sq);
        w_sat  = (|w_sum[edu_pkg::SUM_W-1:edu_pkg::ACC_W]) ? edu_pkg::ACC_MAX
                                                           : w_sum[edu_pkg::ACC_W-1:0];
    end

    assign o_push.valid = r_v2 && r_last2 && w_adv;
    assign o_push.sum   = w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else if (w_adv) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_last2 ? '0 : w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_last1 <= i_pair.last;
            r_mag   <= w_abs[edu_pkg::ELEM_W-1:0];
            r_last2 <= r_last1;
            r_sq    <= edu_pkg::SQ_W'(r_mag) * edu_pkg::SQ_W'(r_mag);
        end
    end

endmodule

// ===== hw/rtl/edu_queue.sv =====
// Short queue of finished sums between the front end and the square root back end.
// Depends on edu_pkg and euclidean_distance_unit_defines.svh.
`include "euclidean_distance_unit_defines.svh"

module edu_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  edu_pkg::t_sum_xfer  i_push,
    input  logic                i_pop,
    output edu_pkg::t_sum_xfer  o_head,
    output logic                o_full
);

    logic [edu_pkg::ACC_W-1:0] r_mem [edu_pkg::Q_DEPTH];
    logic [edu_pkg::Q_AW-1:0]  r_wptr;
    logic [edu_pkg::Q_AW-1:0]  r_rptr;
    logic [edu_pkg::Q_AW:0]    r_count;

    assign o_full       = (r_count == (edu_pkg::Q_AW+1)'(edu_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.sum   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push.valid && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.sum;
        end
    end

    `EDU_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push.valid, !o_full, "push into full queue")
    `EDU_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_head.valid, "pop from empty queue")
    `EDU_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push.valid && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow")

endmodule

// ===== hw/rtl/edu_back.sv =====
// Back end: restoring square root, one result bit per cycle, and the result register.
// Depends on edu_pkg, edu_out_if and euclidean_distance_unit_defines.svh.
`include "euclidean_distance_unit_defines.svh"

module edu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  edu_pkg::t_sum_xfer  i_head,
    output logic                o_pop,
    edu_out_if.source           o_res
);

    edu_pkg::t_back_state          r_state;
    edu_pkg::t_back_state          n_state;
    logic [edu_pkg::RAD_W-1:0]     r_x;
    logic [edu_pkg::RAD_W-1:0]     n_x;
    logic [edu_pkg::DIST_W-1:0]    r_root;
    logic [edu_pkg::DIST_W-1:0]    n_root;
    logic [edu_pkg::REM_W-1:0]     r_rem;
    logic [edu_pkg::REM_W-1:0]     n_rem;
    logic [edu_pkg::CNT_W-1:0]     r_cnt;
    logic [edu_pkg::CNT_W-1:0]     n_cnt;
    logic [edu_pkg::ACC_W-1:0]     r_sum;
    logic [edu_pkg::ACC_W-1:0]     n_sum;
    logic [edu_pkg::REM_W+1:0]     w_rem_sh;
    logic [edu_pkg::REM_W+1:0]     w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edu_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_root <= n_root;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_sum  <= n_sum;
    end

    // Each step brings down the next two radicand bits and tries root*4+1.
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_root      = r_root;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        o_pop       = 1'b0;
        o_res.valid = 1'b0;
        w_rem_sh    = {r_rem, r_x[edu_pkg::RAD_W-1 -: 2]};
        w_trial     = {2'b00, r_root, 2'b01};
        unique case (r_state)
            edu_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_x     = edu_pkg::RAD_W'(i_head.sum);
                    n_root  = '0;
                    n_rem   = '0;
                    n_cnt   = edu_pkg::CNT_W'(edu_pkg::DIST_W - 1);
                    n_sum   = i_head.sum;
                    n_state = edu_pkg::BK_CALC;
                end
            end
            edu_pkg::BK_CALC: begin
                n_x = {r_x[edu_pkg::RAD_W-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    n_rem  = edu_pkg::REM_W'(w_rem_sh - w_trial);
                    n_root = {r_root[edu_pkg::DIST_W-2:0], 1'b1};
                end else begin
                    n_rem  = edu_pkg::REM_W'(w_rem_sh);
                    n_root = {r_root[edu_pkg::DIST_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = edu_pkg::BK_DONE;
                end
            end
            edu_pkg::BK_DONE: begin
                o_res.valid = 1'b1;
                if (o_res.ready) begin
                    n_state = edu_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = edu_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_res.distance    = r_root;
    assign o_res.squared_sum = r_sum;

    `EDU_ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, r_state == edu_pkg::BK_CALC, r_rem <= {r_root, 1'b0}, "partial remainder exceeds twice the root")
    `EDU_ASSERT_IMP(a_root_floor, i_clk, i_rst_n, o_res.valid, (45'(r_root) * 45'(r_root)) <= 45'(r_sum) && ((45'(r_root) + 45'd1) * (45'(r_root) + 45'd1)) > 45'(r_sum), "distance is not the floor square root")

endmodule

// ===== hw/rtl/euclidean_distance_unit.sv =====
// Top level of the euclidean distance unit: front end, sum queue and square root back end.
// Depends on edu_pkg, edu_if, edu_front, edu_queue and edu_back.
//
//  channel   direction  payload                        transaction
//  i_pair    in         elem_a, elem_b, last           valid && ready
//  o_res     out        distance, squared_sum          valid && ready
//
// Element pairs are taken one per cycle while i_pair.ready is high, each passing the
// magnitude and square registers. The back end loads a sum, finds 22 root bits and
// holds the result; its one bit per cycle and o_res back-pressure can limit vector rate.
// i_pair.ready falls only when a vector end meets a full two-entry queue.
// Reset is synchronous and clears the accumulator, the queue and both control paths.
module euclidean_distance_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    edu_in_if.sink      i_pair,
    edu_out_if.source   o_res
);

    edu_pkg::t_sum_xfer w_push;
    edu_pkg::t_sum_xfer w_head;
    logic               w_q_full;
    logic               w_pop;

    edu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (i_pair),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    edu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full)
    );

    edu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
